// File: rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg - shared types and constants for text extent measurement
// word layouts, queue entry, configuration set and fixed constants
// ----------------------------------------------------------------------------
package tem_pkg;

  typedef struct packed {
    logic              func;
    logic [7:0]        char_code;
    logic              has_char;
    logic              end_of_text;
    logic signed [7:0] left_bearing_in;
    logic signed [7:0] right_bearing_in;
    logic [7:0]        glyph_width_in;
  } in_word_t;

  typedef struct packed {
    logic [23:0] text_width;
    logic [23:0] text_height;
    logic [15:0] line_total;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_NEWLINE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              eot;
    logic signed [7:0] lb;
    logic signed [7:0] rb;
    logic [7:0]        gw;
  } meas_t;

  typedef struct packed {
    logic [15:0] size_ratio;
    logic [7:0]  font_size;
    logic [7:0]  base_line_spacing;
    logic [11:0] line_spacing_ratio;
    logic        bold_enable;
    logic        italic_enable;
  } cfg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_RATIO         = 3'd0,
    REG_FONT_SIZE          = 3'd1,
    REG_BASE_LINE_SPACING  = 3'd2,
    REG_LINE_SPACING_RATIO = 3'd3,
    REG_BOLD_ENABLE        = 3'd4,
    REG_ITALIC_ENABLE      = 3'd5
  } reg_index_t;

  localparam logic [15:0] RST_SIZE_RATIO         = 16'd256;
  localparam logic [7:0]  RST_FONT_SIZE          = 8'd16;
  localparam logic [7:0]  RST_BASE_LINE_SPACING  = 8'd16;
  localparam logic [11:0] RST_LINE_SPACING_RATIO = 12'd256;

  localparam logic [14:0] TAN20_Q16  = 15'd23853;
  localparam logic [9:0]  BOLD_EXTRA = 10'd512;
  localparam logic [7:0]  CODE_LF    = 8'd10;
  localparam logic [7:0]  CODE_CR    = 8'd13;
  localparam logic [23:0] MAX24      = 24'hFFFFFF;
  localparam logic [15:0] MAX16      = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

// File: rtl/tem_stream_if.sv
// ----------------------------------------------------------------------------
// tem_stream_if - valid/ready channel
// carries one word per handshake, payload type chosen per instance
// ----------------------------------------------------------------------------
interface tem_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/text_extent_measure.sv
// ----------------------------------------------------------------------------
// text_extent_measure - bitmap font text extent measurement
// streams characters, accumulates line widths, reports width and height
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  in_ch     in   valid/ready        tem_pkg::in_word_t
//  out_ch    out  valid/ready        tem_pkg::out_word_t
//  cfg_*     in   cfg_we, no wait    cfg_index, cfg_data
//
//  front: one word a cycle until the queue fills, a lookup stage, a four-entry queue
//  back: character = pop, scale, accumulate; newline = pop, close line; other = pop
//  end of text: close line, three height multiplies, sum, output; only output if empty
//  synchronous active-low reset; the glyph memory is not cleared
//  a waiting result holds the back at its next output; the front keeps filling the queue
module text_extent_measure #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tem_stream_if.sink                        in_ch,
  tem_stream_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [tem_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tem_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tem_pkg::cfg_t  cfg_r;
  tem_pkg::meas_t push_entry;
  tem_pkg::meas_t pop_entry;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_ratio         <= tem_pkg::RST_SIZE_RATIO;
      cfg_r.font_size          <= tem_pkg::RST_FONT_SIZE;
      cfg_r.base_line_spacing  <= tem_pkg::RST_BASE_LINE_SPACING;
      cfg_r.line_spacing_ratio <= tem_pkg::RST_LINE_SPACING_RATIO;
      cfg_r.bold_enable        <= 1'b0;
      cfg_r.italic_enable      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tem_pkg::REG_SIZE_RATIO:         cfg_r.size_ratio         <= cfg_data;
        tem_pkg::REG_FONT_SIZE:          cfg_r.font_size          <= cfg_data[7:0];
        tem_pkg::REG_BASE_LINE_SPACING:  cfg_r.base_line_spacing  <= cfg_data[7:0];
        tem_pkg::REG_LINE_SPACING_RATIO: cfg_r.line_spacing_ratio <= cfg_data[11:0];
        tem_pkg::REG_BOLD_ENABLE:        cfg_r.bold_enable        <= cfg_data[0];
        tem_pkg::REG_ITALIC_ENABLE:      cfg_r.italic_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tem_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_ch.data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  tem_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  tem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.data)
  );

endmodule

// File: rtl/tem_front.sv
// ----------------------------------------------------------------------------
// tem_front - input acceptance and classification
// owns the glyph metric memory, writes entries and looks up metrics
// ----------------------------------------------------------------------------
module tem_front #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tem_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              q_push,
  output tem_pkg::meas_t    q_entry
);

  localparam int DEPTH = (GLYPH_COUNT < 256) ? GLYPH_COUNT : 256;
  localparam int AW    = $clog2(DEPTH);

  logic [23:0]     mem [DEPTH];
  logic [23:0]     rd_r;
  logic            stg_valid_r;
  logic            stg_valid_nxt;
  tem_pkg::op_t    stg_op_r;
  logic            stg_eot_r;
  logic            stg_hit_r;
  logic            accept;
  logic            in_range;
  logic [AW-1:0]   idx;
  tem_pkg::op_t    op_cls;

  assign accept   = in_valid && in_ready;
  assign in_ready = !stg_valid_r || !q_full;
  assign q_push   = stg_valid_r && !q_full;
  assign in_range = (GLYPH_COUNT >= 256) || (int'(in_word.char_code) < GLYPH_COUNT);
  assign idx      = in_word.char_code[AW-1:0];

  always_comb begin
    op_cls = tem_pkg::OP_NONE;
    if (in_word.has_char && in_word.char_code != tem_pkg::CODE_CR) begin
      op_cls = (in_word.char_code == tem_pkg::CODE_LF) ? tem_pkg::OP_NEWLINE
                                                       : tem_pkg::OP_CHAR;
    end
  end

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = !in_word.func;
    end else if (q_push) begin
      stg_valid_nxt = 1'b0;
    end
  end

  // glyph metric memory: width 7:0, left bearing 15:8, right bearing 23:16
  always_ff @(posedge clk) begin
    if (accept && in_word.func && in_range) begin
      mem[idx] <= {in_word.right_bearing_in, in_word.left_bearing_in,
                   in_word.glyph_width_in};
    end
    if (accept) begin
      rd_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
    if (accept) begin
      stg_op_r  <= op_cls;
      stg_eot_r <= in_word.end_of_text;
      stg_hit_r <= in_range;
    end
  end

  always_comb begin
    q_entry.op  = stg_op_r;
    q_entry.eot = stg_eot_r;
    q_entry.gw  = stg_hit_r ? rd_r[7:0] : 8'd0;
    q_entry.lb  = stg_hit_r ? signed'(rd_r[15:8]) : 8'sd0;
    q_entry.rb  = stg_hit_r ? signed'(rd_r[23:16]) : 8'sd0;
  end

endmodule

// File: rtl/tem_queue.sv
// ----------------------------------------------------------------------------
// tem_queue - short queue between front and back
// holds classified words so that either side can stall on its own
// ----------------------------------------------------------------------------
module tem_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tem_pkg::meas_t push_entry,
  input  logic           pop,
  output tem_pkg::meas_t pop_entry,
  output logic           full,
  output logic           empty
);

  tem_pkg::meas_t                slot_r [tem_pkg::QUEUE_DEPTH];
  logic [tem_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [tem_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [tem_pkg::QUEUE_AW:0]    count_r;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count_r == (tem_pkg::QUEUE_AW+1)'(tem_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/tem_back.sv
// ----------------------------------------------------------------------------
// tem_back - line accumulation and result generation
// sequencer over glyph scaling, line closing and the height multiplies
// ----------------------------------------------------------------------------
module tem_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tem_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  tem_pkg::meas_t     q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tem_pkg::out_word_t out_word
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_NEWLINE,
    B_END,
    B_H1,
    B_H2,
    B_H3,
    B_H4,
    B_OUT
  } state_t;

  state_t              state_r;
  tem_pkg::meas_t      op_r;
  logic signed [31:0]  line_accum_r;
  logic [23:0]         max_width_r;
  logic signed [23:0]  pending_r;
  logic [15:0]         line_counter_r;
  logic                seen_r;
  logic signed [27:0]  prod_r;
  logic signed [23:0]  neg_r;
  logic [23:0]         h_r;
  logic [15:0]         lines_r;
  logic [35:0]         t_r;
  logic [51:0]         u_r;
  logic [23:0]         height_r;
  logic                out_valid_r;
  tem_pkg::out_word_t  out_word_r;

  logic [22:0]         ital_prod;
  logic [14:0]         ital_off;
  logic signed [32:0]  w_sum;
  logic [23:0]         close_w;
  logic [23:0]         max_nxt;
  logic signed [10:0]  glyph_sum;
  logic signed [16:0]  ratio_s;
  logic signed [33:0]  acc_sum;
  logic signed [31:0]  acc_sat;
  logic [44:0]         h_sum;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign ratio_s   = signed'({1'b0, cfg.size_ratio});

  // line closing: italic slant, clamp to 0..max, widest line
  always_comb begin
    ital_prod = 23'(cfg.font_size) * 23'(tem_pkg::TAN20_Q16) + 23'd128;
    ital_off  = cfg.italic_enable ? ital_prod[22:8] : 15'd0;
    w_sum     = 33'(line_accum_r) + 33'({18'd0, ital_off});
    if (w_sum[32]) begin
      close_w = 24'd0;
    end else if (|w_sum[31:24]) begin
      close_w = tem_pkg::MAX24;
    end else begin
      close_w = w_sum[23:0];
    end
    max_nxt = (close_w > max_width_r) ? close_w : max_width_r;
  end

  always_comb begin
    glyph_sum = 11'(op_r.lb) + 11'({1'b0, op_r.gw}) + (op_r.rb[7] ? 11'd0 : 11'(op_r.rb));
    acc_sum   = 34'(line_accum_r) + 34'(pending_r) + 34'(prod_r)
              + (cfg.bold_enable ? 34'({24'd0, tem_pkg::BOLD_EXTRA}) : 34'd0);
    if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111) begin
      acc_sat = acc_sum[31:0];
    end else if (acc_sum[33]) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = 32'sh7FFF_FFFF;
    end
    h_sum = 45'(h_r) + 45'(u_r[51:8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= B_IDLE;
      out_valid_r    <= 1'b0;
      line_accum_r   <= '0;
      max_width_r    <= '0;
      pending_r      <= '0;
      line_counter_r <= '0;
      seen_r         <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            op_r <= q_entry;
            case (q_entry.op)
              tem_pkg::OP_CHAR: begin
                seen_r  <= 1'b1;
                state_r <= B_MUL;
              end
              tem_pkg::OP_NEWLINE: begin
                state_r <= B_NEWLINE;
              end
              default: begin
                state_r <= q_entry.eot ? B_END : B_IDLE;
              end
            endcase
          end
        end
        B_MUL: begin
          prod_r  <= 28'(glyph_sum) * 28'(ratio_s);
          neg_r   <= 24'(op_r.rb) * 24'(ratio_s);
          state_r <= B_ACC;
        end
        B_ACC: begin
          line_accum_r <= acc_sat;
          pending_r    <= op_r.rb[7] ? neg_r : 24'sd0;
          state_r      <= op_r.eot ? B_END : B_IDLE;
        end
        B_NEWLINE: begin
          max_width_r  <= max_nxt;
          line_accum_r <= '0;
          pending_r    <= '0;
          seen_r       <= 1'b1;
          if (line_counter_r != tem_pkg::MAX16) begin
            line_counter_r <= line_counter_r + 16'd1;
          end
          state_r <= op_r.eot ? B_END : B_IDLE;
        end
        B_END: begin
          if (seen_r) begin
            max_width_r  <= max_nxt;
            line_accum_r <= '0;
            pending_r    <= '0;
            state_r      <= B_H1;
          end else begin
            state_r <= B_OUT;
          end
        end
        B_H1: begin
          h_r     <= 24'(cfg.base_line_spacing) * 24'(cfg.size_ratio);
          lines_r <= (line_counter_r == tem_pkg::MAX16) ? tem_pkg::MAX16
                                                        : line_counter_r + 16'd1;
          state_r <= B_H2;
        end
        B_H2: begin
          t_r     <= 36'(h_r) * 36'(cfg.line_spacing_ratio);
          state_r <= B_H3;
        end
        B_H3: begin
          u_r     <= 52'(t_r) * 52'(lines_r - 16'd1);
          state_r <= B_H4;
        end
        B_H4: begin
          height_r <= (|h_sum[44:24]) ? tem_pkg::MAX24 : h_sum[23:0];
          state_r  <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_word_r.text_width  <= max_width_r;
            out_word_r.text_height <= seen_r ? height_r : 24'd0;
            out_word_r.line_total  <= seen_r ? lines_r : 16'd0;
            line_accum_r           <= '0;
            max_width_r            <= '0;
            pending_r              <= '0;
            line_counter_r         <= '0;
            seen_r                 <= 1'b0;
            state_r                <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tem_checker.sv
// ----------------------------------------------------------------------------
// tem_checker - port-level checks for text extent measurement
// result channel behaviour and result consistency, bound to the top level
// ----------------------------------------------------------------------------
module tem_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tem_pkg::out_word_t out_word
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its word
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // empty text gives an all-zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.line_total == 16'd0 |->
      out_word.text_width == 24'd0 && out_word.text_height == 24'd0)
    else $error("empty text with non-zero extent");

  // nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind text_extent_measure tem_checker u_tem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.data)
);
